### rtl/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 LPM shared definitions
// Default sizes, field widths, item codes, and the command and status types
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iplpm_pkg;

    // Default trie geometry.
    localparam int DEF_FIRST_LEVEL_BITS = 16;
    localparam int DEF_LEVEL_BITS       = 8;
    localparam int DEF_NODE_POOL        = 256;
    localparam int DEF_HOP_BITS         = 32;

    // Fixed field widths of the item and result.
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int HOP_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOROUTE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOPOOL  = 2'd2;

    // Datapath commands, one per cycle.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RD_WALK,
        CMD_S_CHK,
        CMD_CNT_RD,
        CMD_I_INC,
        CMD_RD_FILL,
        CMD_I_FILL,
        CMD_I_CHK,
        CMD_ALLOC,
        CMD_I_LINK,
        CMD_FAIL,
        CMD_R_DEC,
        CMD_R_FILL,
        CMD_R_CHK,
        CMD_R_UNLINK,
        CMD_R_OK,
        CMD_FINISH
    } dp_cmd_t;

    // Datapath status flags seen by the controller.
    typedef struct packed {
        logic clr_last;
        logic len_zero;
        logic next_bad;
        logic last_level;
        logic fill_here;
        logic fill_end;
        logic pool_empty;
        logic cover_req;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/iplpm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iplpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/iplpm_datapath.sv
// ----------------------------------------------------------------------------
// IPv4 LPM datapath
// Holds the trie entry, use count and free list memories, the walk registers
// and the result register, and carries out one controller command a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iplpm_datapath #(
    parameter int FIRST_LEVEL_BITS = iplpm_pkg::DEF_FIRST_LEVEL_BITS,
    parameter int LEVEL_BITS       = iplpm_pkg::DEF_LEVEL_BITS,
    parameter int NODE_POOL        = iplpm_pkg::DEF_NODE_POOL,
    parameter int HOP_BITS         = iplpm_pkg::DEF_HOP_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire iplpm_pkg::dp_cmd_t                   cmd,
    output iplpm_pkg::dp_status_t                     st,
    input  wire logic [iplpm_pkg::MODE_W-1:0]         mode,
    input  wire logic [iplpm_pkg::ADDR_W-1:0]         address,
    input  wire logic [iplpm_pkg::LEN_W-1:0]          pfx_len,
    input  wire logic [iplpm_pkg::HOP_W-1:0]          next_hop,
    input  wire logic                                 cover_valid,
    input  wire logic [iplpm_pkg::ADDR_W-1:0]         cover_address,
    input  wire logic [iplpm_pkg::LEN_W-1:0]          cover_len,
    input  wire logic [iplpm_pkg::HOP_W-1:0]          cover_next_hop,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [iplpm_pkg::STATUS_W-1:0]       status,
    output logic      [iplpm_pkg::HOP_W-1:0]          result_hop
);

    import iplpm_pkg::*;

    localparam int ROOT_SIZE   = 1 << FIRST_LEVEL_BITS;
    localparam int ENTRY_COUNT = ROOT_SIZE + NODE_POOL * (1 << LEVEL_BITS);
    localparam int AW          = $clog2(ENTRY_COUNT);
    localparam int NB          = $clog2(NODE_POOL + 1);
    localparam int FB          = $clog2(NODE_POOL);
    localparam int IW          = (FIRST_LEVEL_BITS > LEVEL_BITS) ? FIRST_LEVEL_BITS
                                                                 : LEVEL_BITS;
    localparam int CNTW        = IW + 1;
    localparam int EW          = LEN_W + NB + HOP_BITS;

    // Clamp a length to 32.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(32)) ? LEN_W'(32) : v;
    endfunction

    // Keep the top m bits of an address.
    function automatic logic [ADDR_W-1:0] prefix_of(input logic [ADDR_W-1:0] a,
                                                    input logic [LEN_W-1:0]  m);
        logic [63:0] ones;
        ones = 64'h0000_0000_FFFF_FFFF << (7'd32 - {1'b0, m});
        return a & ones[31:0];
    endfunction

    // Walk and work registers.
    logic [ADDR_W-1:0]   wa_reg;
    logic [LEN_W-1:0]    wm_reg;
    logic [HOP_BITS-1:0] whop_reg;
    logic                cv_reg;
    logic [ADDR_W-1:0]   ca_reg;
    logic [LEN_W-1:0]    cl_reg;
    logic [HOP_BITS-1:0] ch_reg;
    logic [NB-1:0]       node_reg;
    logic [LEN_W-1:0]    low_reg;
    logic [LEN_W-1:0]    high_reg;
    logic [AW-1:0]       fill_addr_reg;
    logic [CNTW-1:0]     fill_cnt_reg;
    logic [EW-1:0]       ent_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [HOP_W-1:0]    rhop_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HOP_W-1:0]    out_hop_reg;

    // Control registers.
    logic [AW-1:0]       clr_reg;
    logic [NB-1:0]       head_reg;
    logic [NB-1:0]       tail_reg;
    logic                out_valid_reg;

    // Memory ports.
    logic                ent_we;
    logic [AW-1:0]       ent_waddr;
    logic [EW-1:0]       ent_wdata;
    logic [AW-1:0]       ent_raddr;
    logic [EW-1:0]       ent_rdata;
    logic                cnt_we;
    logic [NB-1:0]       cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [NB-1:0]       cnt_raddr;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic                free_we;
    logic [FB-1:0]       free_waddr;
    logic [FB-1:0]       free_wdata;
    logic [FB-1:0]       free_raddr;
    logic [FB-1:0]       free_rdata;

    // Derived walk values.
    logic [31:0]         lvl_shift;
    logic [31:0]         lvl_mask;
    logic [IW-1:0]       idx;
    logic [NB-1:0]       node_m1;
    logic [AW-1:0]       base;
    logic [AW-1:0]       walk_addr;
    logic [LEN_W-1:0]    lo;
    logic [CNTW-1:0]     fill_span;
    logic [LEN_W-1:0]    e_len;
    logic [NB-1:0]       e_next;
    logic [HOP_BITS-1:0] e_hop;
    logic [LEN_W-1:0]    g_len;
    logic [NB-1:0]       g_next;
    logic [HOP_BITS-1:0] g_hop;
    logic                next_bad;
    logic                pool_empty;
    logic                dec_zero;
    logic [LEN_W-1:0]    cl_clamp;

    // Index into the current level and base of the current node.
    assign lvl_shift = wa_reg >> (6'd32 - high_reg);
    assign lvl_mask  = ~(32'hFFFF_FFFF << (high_reg - low_reg));
    assign idx       = IW'(lvl_shift & lvl_mask);
    assign node_m1   = node_reg - NB'(1);
    assign base      = (node_reg == '0) ? '0 : AW'(ROOT_SIZE) + (AW'(node_m1) << LEVEL_BITS);
    assign walk_addr = base + AW'(idx);
    assign lo        = (wm_reg > low_reg) ? wm_reg : low_reg;
    assign fill_span = CNTW'(1) << (high_reg - lo);

    // Fields of the entry just read and of the held entry.
    assign e_len  = ent_rdata[LEN_W-1:0];
    assign e_next = ent_rdata[LEN_W +: NB];
    assign e_hop  = ent_rdata[LEN_W + NB +: HOP_BITS];
    assign g_len  = ent_reg[LEN_W-1:0];
    assign g_next = ent_reg[LEN_W +: NB];
    assign g_hop  = ent_reg[LEN_W + NB +: HOP_BITS];

    assign next_bad   = (e_next == '0) || (e_next > NB'(NODE_POOL));
    assign pool_empty = head_reg >= NB'(NODE_POOL);
    assign dec_zero   = (cnt_rdata == COUNT_W'(1)) && (node_reg != '0);
    assign cl_clamp   = clamp_len(cover_len);

    // Status flags to the controller.
    always_comb
    begin
        st.clr_last   = clr_reg == AW'(ENTRY_COUNT - 1);
        st.len_zero   = e_len == '0;
        st.next_bad   = next_bad;
        st.last_level = ({1'b0, high_reg} + 7'(LEVEL_BITS)) > 7'd32;
        st.fill_here  = wm_reg <= high_reg;
        st.fill_end   = fill_cnt_reg == CNTW'(1);
        st.pool_empty = pool_empty;
        st.cover_req  = cv_reg;
        st.out_busy   = out_valid_reg && !out_ready;
    end

    // Trie entry memory ports.
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = fill_addr_reg;
        ent_wdata = ent_rdata;
        ent_raddr = (cmd == CMD_RD_WALK) ? walk_addr : fill_addr_reg;
        case (cmd)
            CMD_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                ent_wdata = '0;
            end
            CMD_I_FILL:
            begin
                ent_we    = (e_len <= wm_reg) || (e_len > high_reg);
                ent_wdata = {whop_reg, e_next, wm_reg};
            end
            CMD_R_FILL:
            begin
                ent_we    = (e_len == wm_reg) && (e_hop == whop_reg);
                ent_wdata = {e_hop, e_next,
                             (e_next == '0) ? LEN_W'(0) : high_reg + LEN_W'(1)};
            end
            CMD_I_LINK:
            begin
                ent_we    = 1'b1;
                ent_wdata = {g_hop, g_next, (g_len == '0) ? wm_reg : g_len};
            end
            CMD_R_UNLINK:
            begin
                ent_we    = (cnt_rdata == COUNT_W'(1)) && (g_len > high_reg);
                ent_wdata = {g_hop, NB'(0), LEN_W'(0)};
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    // Use count memory ports.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = node_reg;
        cnt_wdata = '0;
        cnt_raddr = (cmd == CMD_R_CHK) ? e_next : node_reg;
        case (cmd)
            CMD_CLEAR:
            begin
                cnt_we    = clr_reg <= AW'(NODE_POOL);
                cnt_waddr = clr_reg[NB-1:0];
            end
            CMD_I_INC:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata + COUNT_W'(1);
            end
            CMD_R_DEC:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata - COUNT_W'(1);
            end
            CMD_ALLOC:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = head_reg + NB'(1);
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Free list memory ports.
    always_comb
    begin
        free_we    = 1'b0;
        free_waddr = tail_reg[FB-1:0];
        free_wdata = node_m1[FB-1:0];
        free_raddr = head_reg[FB-1:0];
        case (cmd)
            CMD_CLEAR:
            begin
                free_we    = clr_reg < AW'(NODE_POOL);
                free_waddr = clr_reg[FB-1:0];
                free_wdata = (clr_reg == AW'(NODE_POOL - 1)) ? FB'(0)
                                                              : clr_reg[FB-1:0] + FB'(1);
            end
            CMD_R_DEC:
            begin
                free_we = dec_zero && !pool_empty;
            end
            default:
            begin
                free_we = 1'b0;
            end
        endcase
    end

    // Control registers: clearing counter, free list ends, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= NB'(NODE_POOL - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_CLEAR && clr_reg != AW'(ENTRY_COUNT - 1))
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd == CMD_ALLOC)
            begin
                if (head_reg == tail_reg)
                begin
                    head_reg <= NB'(NODE_POOL);
                    tail_reg <= NB'(NODE_POOL);
                end
                else
                begin
                    head_reg <= NB'(free_rdata);
                end
            end
            if (cmd == CMD_R_DEC && dec_zero)
            begin
                if (pool_empty)
                begin
                    head_reg <= node_m1;
                end
                tail_reg <= node_m1;
            end
            if (cmd == CMD_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                wa_reg     <= (mode == MODE_SEARCH) ? address
                                                    : prefix_of(address, clamp_len(pfx_len));
                wm_reg     <= clamp_len(pfx_len);
                whop_reg   <= next_hop[HOP_BITS-1:0];
                cv_reg     <= cover_valid;
                ca_reg     <= prefix_of(cover_address, cl_clamp);
                cl_reg     <= cl_clamp;
                ch_reg     <= cover_next_hop[HOP_BITS-1:0];
                node_reg   <= '0;
                low_reg    <= '0;
                high_reg   <= LEN_W'(FIRST_LEVEL_BITS);
                status_reg <= (mode == MODE_INSERT) ? STAT_OK : STAT_NOROUTE;
                rhop_reg   <= '0;
            end
            CMD_S_CHK:
            begin
                if (e_len != '0 && e_len <= high_reg)
                begin
                    status_reg <= STAT_OK;
                    rhop_reg   <= HOP_W'(e_hop);
                end
                if (e_len != '0 && !next_bad)
                begin
                    node_reg <= e_next;
                    low_reg  <= high_reg;
                    high_reg <= high_reg + LEN_W'(LEVEL_BITS);
                end
            end
            CMD_I_INC, CMD_R_DEC:
            begin
                fill_addr_reg <= walk_addr;
                fill_cnt_reg  <= fill_span;
            end
            CMD_I_FILL, CMD_R_FILL:
            begin
                fill_addr_reg <= fill_addr_reg + AW'(1);
                fill_cnt_reg  <= fill_cnt_reg - CNTW'(1);
            end
            CMD_I_CHK, CMD_R_CHK:
            begin
                ent_reg <= ent_rdata;
            end
            CMD_ALLOC:
            begin
                ent_reg[LEN_W +: NB] <= head_reg + NB'(1);
            end
            CMD_I_LINK, CMD_R_UNLINK:
            begin
                node_reg <= g_next;
                low_reg  <= high_reg;
                high_reg <= high_reg + LEN_W'(LEVEL_BITS);
            end
            CMD_FAIL:
            begin
                status_reg <= STAT_NOPOOL;
                rhop_reg   <= '0;
            end
            CMD_R_OK:
            begin
                status_reg <= STAT_OK;
                rhop_reg   <= HOP_W'(whop_reg);
                wa_reg     <= ca_reg;
                wm_reg     <= cl_reg;
                whop_reg   <= ch_reg;
                node_reg   <= '0;
                low_reg    <= '0;
                high_reg   <= LEN_W'(FIRST_LEVEL_BITS);
            end
            CMD_FINISH:
            begin
                out_status_reg <= status_reg;
                out_hop_reg    <= rhop_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign result_hop = out_hop_reg;

    // Trie entries: stored length, child link and next hop.
    iplpm_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRY_COUNT)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Use counts, root at index zero.
    iplpm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NODE_POOL + 1)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Free node chain.
    iplpm_ram #(
        .WIDTH (FB),
        .DEPTH (NODE_POOL)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

endmodule

`default_nettype wire

### rtl/iplpm_ctrl.sv
// ----------------------------------------------------------------------------
// IPv4 LPM controller
// State machine that sequences the clearing pass, searches, inserts and
// removes, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iplpm_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [iplpm_pkg::MODE_W-1:0] mode,
    input  wire iplpm_pkg::dp_status_t        st,
    output iplpm_pkg::dp_cmd_t                cmd
);

    import iplpm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_S_RD,
        S_S_CHK,
        S_I_CNT,
        S_I_INC,
        S_I_FRD,
        S_I_FWR,
        S_I_ERD,
        S_I_CHK,
        S_I_ALLOC,
        S_I_LINK,
        S_I_FAIL,
        S_R_CNT,
        S_R_DEC,
        S_R_FRD,
        S_R_FWR,
        S_R_ERD,
        S_R_CHK,
        S_R_UNLINK,
        S_R_OK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    case (mode)
                        MODE_SEARCH: state_next = S_S_RD;
                        MODE_INSERT: state_next = S_I_CNT;
                        MODE_REMOVE: state_next = S_R_CNT;
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_S_RD:
            begin
                cmd        = CMD_RD_WALK;
                state_next = S_S_CHK;
            end
            S_S_CHK:
            begin
                cmd        = CMD_S_CHK;
                state_next = (st.len_zero || st.next_bad || st.last_level) ? S_FINISH
                                                                             : S_S_RD;
            end
            S_I_CNT:
            begin
                cmd        = CMD_CNT_RD;
                state_next = S_I_INC;
            end
            S_I_INC:
            begin
                cmd        = CMD_I_INC;
                state_next = st.fill_here ? S_I_FRD : S_I_ERD;
            end
            S_I_FRD:
            begin
                cmd        = CMD_RD_FILL;
                state_next = S_I_FWR;
            end
            S_I_FWR:
            begin
                cmd        = CMD_I_FILL;
                state_next = st.fill_end ? S_FINISH : S_I_FRD;
            end
            S_I_ERD:
            begin
                cmd        = CMD_RD_FILL;
                state_next = S_I_CHK;
            end
            S_I_CHK:
            begin
                cmd = CMD_I_CHK;
                if (st.next_bad && st.pool_empty)
                begin
                    state_next = S_I_FAIL;
                end
                else if (st.next_bad)
                begin
                    state_next = S_I_ALLOC;
                end
                else
                begin
                    state_next = S_I_LINK;
                end
            end
            S_I_ALLOC:
            begin
                cmd        = CMD_ALLOC;
                state_next = S_I_LINK;
            end
            S_I_LINK:
            begin
                cmd        = CMD_I_LINK;
                state_next = st.last_level ? S_FINISH : S_I_CNT;
            end
            S_I_FAIL:
            begin
                cmd        = CMD_FAIL;
                state_next = S_FINISH;
            end
            S_R_CNT:
            begin
                cmd        = CMD_CNT_RD;
                state_next = S_R_DEC;
            end
            S_R_DEC:
            begin
                cmd        = CMD_R_DEC;
                state_next = st.fill_here ? S_R_FRD : S_R_ERD;
            end
            S_R_FRD:
            begin
                cmd        = CMD_RD_FILL;
                state_next = S_R_FWR;
            end
            S_R_FWR:
            begin
                cmd        = CMD_R_FILL;
                state_next = st.fill_end ? S_R_OK : S_R_FRD;
            end
            S_R_ERD:
            begin
                cmd        = CMD_RD_FILL;
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                cmd        = CMD_R_CHK;
                state_next = (st.len_zero || st.next_bad) ? S_FINISH : S_R_UNLINK;
            end
            S_R_UNLINK:
            begin
                cmd        = CMD_R_UNLINK;
                state_next = st.last_level ? S_R_OK : S_R_CNT;
            end
            S_R_OK:
            begin
                // The covering route is inserted with the normal insert walk.
                cmd        = CMD_R_OK;
                state_next = st.cover_req ? S_I_CNT : S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd        = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ipv4_multibit_trie_lpm_core.sv
// ----------------------------------------------------------------------------
// IPv4 multibit trie longest-prefix-match core
// A search reads and checks one trie entry per level walked, then registers
// its result; the next item is taken once the core is back in idle. Insert
// and remove update the node use count at each level walked, then read and
// write back each entry of the filled range; a cover re-insert adds an insert
// walk. One item is in work at a time and a held result stalls the next one.
// After reset a clearing pass over all 2^FIRST_LEVEL_BITS + NODE_POOL *
// 2^LEVEL_BITS trie entries (131072) runs before the first item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_multibit_trie_lpm_core #(
    parameter int FIRST_LEVEL_BITS = iplpm_pkg::DEF_FIRST_LEVEL_BITS,
    parameter int LEVEL_BITS       = iplpm_pkg::DEF_LEVEL_BITS,
    parameter int NODE_POOL        = iplpm_pkg::DEF_NODE_POOL,
    parameter int HOP_BITS         = iplpm_pkg::DEF_HOP_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [iplpm_pkg::MODE_W-1:0]   mode,
    input  wire logic [iplpm_pkg::ADDR_W-1:0]   address,
    input  wire logic [iplpm_pkg::LEN_W-1:0]    pfx_len,
    input  wire logic [iplpm_pkg::HOP_W-1:0]    next_hop,
    input  wire logic                           cover_valid,
    input  wire logic [iplpm_pkg::ADDR_W-1:0]   cover_address,
    input  wire logic [iplpm_pkg::LEN_W-1:0]    cover_len,
    input  wire logic [iplpm_pkg::HOP_W-1:0]    cover_next_hop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [iplpm_pkg::STATUS_W-1:0] status,
    output logic      [iplpm_pkg::HOP_W-1:0]    result_hop
);

    import iplpm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    // Sequencer.
    iplpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .st       (st),
        .cmd      (cmd)
    );

    // Memories and walk registers.
    iplpm_datapath #(
        .FIRST_LEVEL_BITS (FIRST_LEVEL_BITS),
        .LEVEL_BITS       (LEVEL_BITS),
        .NODE_POOL        (NODE_POOL),
        .HOP_BITS         (HOP_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .mode           (mode),
        .address        (address),
        .pfx_len        (pfx_len),
        .next_hop       (next_hop),
        .cover_valid    (cover_valid),
        .cover_address  (cover_address),
        .cover_len      (cover_len),
        .cover_next_hop (cover_next_hop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_hop     (result_hop)
    );

endmodule

`default_nettype wire
